// File: src/poisson_neuron_update_defines.svh
// Assertion macros for the poisson neuron update block.
// Included by the top level; no other dependencies.
`ifndef POISSON_NEURON_UPDATE_DEFINES_SVH
`define POISSON_NEURON_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PNU_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pnu assertion failed");
`define PNU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pnu assertion failed");
`else
`define PNU_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define PNU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: src/pnu_pkg.sv
// Package for the poisson neuron update block: widths, register indexes, reset values.
// No dependencies.
`default_nettype none

package pnu_pkg;

    localparam int NEURONS_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 16;

    localparam int ACT_W   = 24;
    localparam int IDX_W   = 10;
    localparam int THR_W   = 16;
    localparam int RECIP_W = 17;
    localparam int STEPS_W = 8;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    typedef logic signed [ACT_W-1:0] act_t;

    localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TAU     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY  = 3'd4;

    localparam act_t                 REST_LEVEL_RST = 24'sd3277;
    localparam logic [RECIP_W-1:0]   INV_TAU_RST    = 17'd13107;
    localparam logic [STEPS_W-1:0]   STEPS_RST      = 8'd10;
    localparam logic [RECIP_W-1:0]   INV_STEPS_RST  = 17'd6554;
    localparam logic [CNT_W-1:0]     REFRACTORY_RST = 16'd4;

    localparam act_t ACT_MAX = 24'sh7FFFFF;
    localparam act_t ACT_MIN = -24'sh800000;

endpackage

`default_nettype wire

// File: src/pnu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pnu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: src/poisson_neuron_update.sv
// Poisson spiking neuron update: activity and refractory counters in RAM,
// multi-cycle Euler integration. Depends on pnu_pkg, pnu_ram and the defines header.
//
//  channel | dir | beat fields
//  s_      | in  | tdata: neuron_index, input_current, random_threshold; tuser: disabled
//  m_      | out | tdata: result_index, fired, activity
//  cfg_    | in  | cfg_index, cfg_data (register write)
//
// An item passes through READ, then MUL1, MUL2 and ACC for each Euler step, then FIN;
// each Euler step uses the multiply path (two products, then accumulate).
// After reset a clearing pass over every address zeroes both RAMs; s_tready is low then.
// Disabled or out-of-range items are taken and dropped; the block stays idle.
// A held result in the m_ register stalls only the final write-back state (FIN).
`default_nettype none

`include "poisson_neuron_update_defines.svh"

module poisson_neuron_update
    import pnu_pkg::*;
#(
    parameter int NEURONS   = NEURONS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [9:0] neuron_index, [33:10] input_current, [49:34] random_threshold, [55:50] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] disabled
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [9:0] result_index, [10] fired, [34:11] activity, [39:35] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int RNG_W = 18;
    localparam int P1W = ACT_W + 1 + RECIP_W + 1;
    localparam int TW  = P1W - FRAC_BITS;
    localparam int UW  = ((TW > ACT_W) ? TW : ACT_W) + 1;
    localparam int P2W = UW + RECIP_W + 1;
    localparam int DW  = P2W - FRAC_BITS;
    localparam int SW  = ((DW > ACT_W) ? DW : ACT_W) + 1;
    localparam int LS  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int RS  = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int CW  = ACT_W + 8 + 2;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL1  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // configuration
    act_t               rest_reg;
    logic [RECIP_W-1:0] inv_tau_reg;
    logic [STEPS_W-1:0] steps_cfg_reg;
    logic [RECIP_W-1:0] inv_steps_reg;
    logic [CNT_W-1:0]   period_reg;

    // sequencer and datapath
    logic [2:0]            state_reg;
    logic [AW-1:0]         clr_reg;
    logic [IDX_W-1:0]      idx_reg;
    act_t                  cur_reg;
    logic [THR_W-1:0]      thr_reg;
    act_t                  x_reg;
    act_t                  x_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [STEPS_W-1:0]    steps_reg;
    logic signed [P1W-1:0] p1_reg;
    logic signed [P2W-1:0] p2_reg;

    logic                  m_valid_reg;
    logic [IDX_W-1:0]      m_idx_reg;
    logic                  m_fired_reg;
    act_t                  m_act_reg;

    logic                    s_acc;
    logic                    in_range;
    logic                    fin_go;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    act_t                    act_wdata;
    logic [CNT_W-1:0]        cnt_wdata;
    logic [ACT_W-1:0]        act_rdata;
    logic [CNT_W-1:0]        cnt_rdata;
    logic signed [ACT_W:0]   diff;
    logic signed [TW-1:0]    t_val;
    logic signed [UW-1:0]    u_val;
    logic signed [DW-1:0]    dx;
    logic signed [SW-1:0]    sum;
    logic signed [CW-1:0]    lhs;
    logic signed [CW-1:0]    rhs;
    logic                    fire;
    logic [CNT_W-1:0]        cnt_new;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = (RNG_W'(s_tdata[IDX_W-1:0]) < RNG_W'(NEURONS));
    assign fin_go    = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    // Euler step datapath
    assign diff  = (ACT_W+1)'(rest_reg) - (ACT_W+1)'(x_reg);
    assign t_val = TW'(p1_reg >>> FRAC_BITS);
    assign u_val = UW'(t_val) + UW'(cur_reg);
    assign dx    = DW'(p2_reg >>> FRAC_BITS);
    assign sum   = SW'(x_reg) + SW'(dx);

    always_comb begin
        if (sum > SW'(ACT_MAX)) begin
            x_next = ACT_MAX;
        end else if (sum < SW'(ACT_MIN)) begin
            x_next = ACT_MIN;
        end else begin
            x_next = ACT_W'(sum);
        end
    end

    // firing decision on a common scale
    assign lhs  = CW'(x_reg) <<< LS;
    assign rhs  = $signed(CW'(thr_reg)) <<< RS;
    assign fire = (cnt_reg == '0) && (lhs >= rhs);

    always_comb begin
        if (cnt_reg != '0) begin
            cnt_new = cnt_reg - CNT_W'(1);
        end else if (fire) begin
            cnt_new = period_reg;
        end else begin
            cnt_new = '0;
        end
    end

    // RAM ports
    assign ram_we    = (state_reg == ST_CLEAR) || fin_go;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : AW'(idx_reg);
    assign ram_raddr = AW'(s_tdata[IDX_W-1:0]);
    assign act_wdata = (state_reg == ST_CLEAR) ? '0 : x_reg;
    assign cnt_wdata = (state_reg == ST_CLEAR) ? '0 : cnt_new;

    pnu_ram #(.WIDTH(ACT_W), .DEPTH(NEURONS)) u_act_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (act_wdata),
        .raddr (ram_raddr),
        .rdata (act_rdata)
    );

    pnu_ram #(.WIDTH(CNT_W), .DEPTH(NEURONS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cnt_wdata),
        .raddr (ram_raddr),
        .rdata (cnt_rdata)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_reg      <= REST_LEVEL_RST;
            inv_tau_reg   <= INV_TAU_RST;
            steps_cfg_reg <= STEPS_RST;
            inv_steps_reg <= INV_STEPS_RST;
            period_reg    <= REFRACTORY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_REST_LEVEL: rest_reg      <= cfg_data[ACT_W-1:0];
                REG_INV_TAU:    inv_tau_reg   <= cfg_data[RECIP_W-1:0];
                REG_STEPS:      steps_cfg_reg <= cfg_data[STEPS_W-1:0];
                REG_INV_STEPS:  inv_steps_reg <= cfg_data[RECIP_W-1:0];
                REG_REFRACTORY: period_reg    <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(NEURONS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc && !s_tuser && in_range) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= (steps_reg == '0) ? ST_FIN : ST_MUL1;
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_ACC;
                ST_ACC: begin
                    state_reg <= (steps_reg == STEPS_W'(1)) ? ST_FIN : ST_MUL1;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            idx_reg   <= s_tdata[IDX_W-1:0];
            cur_reg   <= s_tdata[IDX_W+ACT_W-1:IDX_W];
            thr_reg   <= s_tdata[IDX_W+ACT_W+THR_W-1:IDX_W+ACT_W];
            steps_reg <= steps_cfg_reg;
        end
        if (state_reg == ST_READ) begin
            x_reg   <= act_rdata;
            cnt_reg <= cnt_rdata;
        end
        if (state_reg == ST_MUL1) begin
            p1_reg <= diff * $signed({1'b0, inv_tau_reg});
        end
        if (state_reg == ST_MUL2) begin
            p2_reg <= u_val * $signed({1'b0, inv_steps_reg});
        end
        if (state_reg == ST_ACC) begin
            x_reg     <= x_next;
            steps_reg <= steps_reg - STEPS_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_idx_reg   <= idx_reg;
            m_fired_reg <= fire;
            m_act_reg   <= x_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - IDX_W - 1 - ACT_W)'(0), m_act_reg, m_fired_reg, m_idx_reg};

    `PNU_ASSERT_IMPLY(a_no_accept_in_clear, aclk, aresetn,
        state_reg == ST_CLEAR, !s_tready)
    `PNU_ASSERT_IMPLY(a_ram_write_owner, aclk, aresetn,
        ram_we, state_reg == ST_CLEAR || state_reg == ST_FIN)
    `PNU_ASSERT_IMPLY(a_step_count_live, aclk, aresetn,
        state_reg == ST_MUL1 || state_reg == ST_MUL2 || state_reg == ST_ACC,
        steps_reg != '0)
    `PNU_ASSERT_NEXT(a_fin_gives_result, aclk, aresetn,
        fin_go, m_tvalid && state_reg == ST_IDLE)

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for poisson_neuron_update: a directed table, then randomized phases over several
// register settings; each result beat is checked against its table row or a neuron predictor.
// Depends on pnu_pkg and the poisson_neuron_update RTL.
`timescale 1ns / 100ps

module tb_top
    import pnu_pkg::*;
();

    localparam int STALL_LIMIT = 5000;
    localparam longint ACT_HI = 64'sd8388607;
    localparam longint ACT_LO = -64'sd8388608;
    localparam act_t CUR_MAX = 24'sh7FFFFF;
    localparam act_t CUR_MIN = 24'sh800000;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        act_t             cur;
        logic [THR_W-1:0] thr;
        logic             dis;
    } neuron_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             fired;
        act_t             act;
    } neuron_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        neuron_req_t           req;
        logic                  chk;
        logic                  exp_fired;
        act_t                  exp_act;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_PULSE} rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    act_t               rest_cfg      = REST_LEVEL_RST;
    logic [RECIP_W-1:0] inv_tau_cfg   = INV_TAU_RST;
    logic [STEPS_W-1:0] steps_cfg     = STEPS_RST;
    logic [RECIP_W-1:0] inv_steps_cfg = INV_STEPS_RST;
    logic [CNT_W-1:0]   refr_cfg      = REFRACTORY_RST;
    act_t               activity_mem [NEURONS_DEF];
    logic [CNT_W-1:0]   refr_mem     [NEURONS_DEF];

    neuron_res_t expected_q[$];
    dir_row_t    dir_table[$];
    int          err_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;

    poisson_neuron_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        foreach (activity_mem[i]) begin
            activity_mem[i] = '0;
            refr_mem[i] = '0;
        end
    end

    function automatic bit neuron_update(input neuron_req_t r, output neuron_res_t res);
        longint x;
        longint t;
        longint dx;
        int k;
        res = '0;
        if (r.dis)
            return 1'b0;
        x = longint'(activity_mem[r.idx]);
        for (k = 0; k < int'(steps_cfg); k++) begin
            t = ((longint'(rest_cfg) - x) * longint'(inv_tau_cfg)) >>> FRAC_BITS_DEF;
            dx = ((t + longint'(r.cur)) * longint'(inv_steps_cfg)) >>> FRAC_BITS_DEF;
            x = x + dx;
            if (x > ACT_HI)
                x = ACT_HI;
            else if (x < ACT_LO)
                x = ACT_LO;
        end
        if (refr_mem[r.idx] == '0) begin
            if (x >= longint'(r.thr)) begin
                res.fired = 1'b1;
                refr_mem[r.idx] = refr_cfg;
            end
        end else begin
            refr_mem[r.idx] = refr_mem[r.idx] - 1'b1;
        end
        activity_mem[r.idx] = act_t'(x);
        res.idx = r.idx;
        res.act = act_t'(x);
        return 1'b1;
    endfunction

    function automatic neuron_req_t rand_req();
        neuron_req_t r;
        // most beats hit a small pool so refractory countdowns get exercised
        r.idx = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 15))
                                           : IDX_W'($urandom_range(0, NEURONS_DEF - 1));
        r.cur = ($urandom_range(0, 3) == 0) ? act_t'($urandom())
                                            : act_t'(int'($urandom_range(0, 524288)) - 262144);
        r.thr = $urandom_range(0, 1) ? THR_W'($urandom()) : THR_W'($urandom_range(0, 4096));
        r.dis = ($urandom_range(0, 9) == 0);
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] v);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = ri;
        row.reg_val = v;
        return row;
    endfunction

    function automatic dir_row_t item_row(logic [IDX_W-1:0] idx, act_t cur, logic [THR_W-1:0] thr,
                                          logic dis, logic chk, logic f, act_t a);
        dir_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.req.idx = idx;
        row.req.cur = cur;
        row.req.thr = thr;
        row.req.dis = dis;
        row.chk = chk;
        row.exp_fired = f;
        row.exp_act = a;
        return row;
    endfunction

    task automatic drive_item(input neuron_req_t r, input logic chk = 1'b0,
                              input logic f = 1'b0, input act_t a = '0);
        neuron_res_t res;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_tdata  <= {6'b0, r.thr, r.cur, r.idx};
        s_tuser  <= r.dis;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (neuron_update(r, res)) begin
            if (chk) begin
                res.fired = f;
                res.act = a;
            end
            expected_q.push_back(res);
        end
    endtask

    // drop valid, drain all results, then cover a dropped beat still in flight
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (3 * int'(steps_cfg) + 8) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (ri)
            REG_REST_LEVEL: rest_cfg = act_t'(v);
            REG_INV_TAU:    inv_tau_cfg = v[RECIP_W-1:0];
            REG_STEPS:      steps_cfg = v[STEPS_W-1:0];
            REG_INV_STEPS:  inv_steps_cfg = v[RECIP_W-1:0];
            REG_REFRACTORY: refr_cfg = v[CNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input act_t rest, input logic [RECIP_W-1:0] tau,
                             input logic [STEPS_W-1:0] steps, input logic [RECIP_W-1:0] isteps,
                             input logic [CNT_W-1:0] refr, input int n_items);
        int done;
        neuron_req_t r;
        settle();
        cfg_write(REG_REST_LEVEL, rest);
        cfg_write(REG_INV_TAU, CFG_DATA_W'(tau));
        cfg_write(REG_STEPS, CFG_DATA_W'(steps));
        cfg_write(REG_INV_STEPS, CFG_DATA_W'(isteps));
        cfg_write(REG_REFRACTORY, CFG_DATA_W'(refr));
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) == 0)
                settle();
            r = rand_req();
            drive_item(r);
            if (!r.dis)
                done++;
        end
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
            RX_SLOW:  m_tready <= ($urandom_range(0, 7) == 0);
            default:  m_tready <= ((rx_left % 16) < 5);
        endcase
    end

    always @(posedge aclk) begin
        neuron_res_t got;
        neuron_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx   = m_tdata[9:0];
            got.fired = m_tdata[10];
            got.act   = m_tdata[34:11];
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: result_index %0d", got.idx);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.idx !== want.idx) begin
                    $error("result_index: expected %0d, got %0d", want.idx, got.idx);
                    err_count++;
                end
                if (got.fired !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired, got.fired);
                    err_count++;
                end
                if (got.act !== want.act) begin
                    $error("activity: expected %0d, got %0d", want.act, got.act);
                    err_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        dir_table = '{
            // no Euler steps: decision on stored activity only
            cfg_row(REG_STEPS, 24'd0),
            item_row(10'd5, 24'sd0, 16'd0, 1'b0, 1'b1, 1'b1, 24'sd0),
            item_row(10'd5, 24'sd0, 16'd0, 1'b0, 1'b1, 1'b0, 24'sd0),
            item_row(10'd6, 24'sd0, 16'd1, 1'b0, 1'b1, 1'b0, 24'sd0),
            item_row(10'd6, CUR_MAX, 16'hFFFF, 1'b1, 1'b0, 1'b0, 24'sd0),
            // pure integrator, one step: saturation at both ends
            cfg_row(REG_INV_TAU, 24'd0),
            cfg_row(REG_INV_STEPS, 24'd65536),
            cfg_row(REG_STEPS, 24'd1),
            item_row(10'd7, CUR_MAX, 16'hFFFF, 1'b0, 1'b1, 1'b1, CUR_MAX),
            item_row(10'd7, CUR_MAX, 16'd0, 1'b0, 1'b1, 1'b0, CUR_MAX),
            item_row(10'd8, CUR_MIN, 16'd0, 1'b0, 1'b1, 1'b0, CUR_MIN),
            item_row(10'd8, CUR_MIN, 16'd0, 1'b0, 1'b1, 1'b0, CUR_MIN),
            // full decay in one step: activity jumps to the rest level
            cfg_row(REG_INV_TAU, 24'd65536),
            cfg_row(REG_REST_LEVEL, 24'h7FFFFF),
            cfg_row(REG_REFRACTORY, 24'd65535),
            item_row(10'd9, 24'sd0, 16'hFFFF, 1'b0, 1'b1, 1'b1, CUR_MAX),
            item_row(10'd9, 24'sd0, 16'd0, 1'b0, 1'b1, 1'b0, CUR_MAX),
            cfg_row(REG_REST_LEVEL, 24'h800000),
            item_row(10'd9, 24'sd0, 16'd0, 1'b0, 1'b1, 1'b0, CUR_MIN),
            item_row(10'd1023, CUR_MAX, 16'd0, 1'b0, 1'b1, 1'b0, -24'sd1),
            item_row(10'd0, CUR_MAX, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'sd0),
            cfg_row(REG_REST_LEVEL, CFG_DATA_W'(REST_LEVEL_RST)),
            cfg_row(REG_INV_TAU, CFG_DATA_W'(INV_TAU_RST)),
            cfg_row(REG_STEPS, CFG_DATA_W'(STEPS_RST)),
            cfg_row(REG_INV_STEPS, CFG_DATA_W'(INV_STEPS_RST)),
            cfg_row(REG_REFRACTORY, CFG_DATA_W'(REFRACTORY_RST)),
            item_row(10'd0, 24'sd0, 16'd0, 1'b0, 1'b0, 1'b0, 24'sd0),
            item_row(10'd1, CUR_MAX, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'sd0),
            item_row(10'd2, CUR_MIN, 16'hFFFF, 1'b0, 1'b0, 1'b0, 24'sd0),
            item_row(10'd1023, 24'sd65536, 16'h8000, 1'b0, 1'b0, 1'b0, 24'sd0)
        };
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.reg_idx, row.reg_val);
            end else begin
                drive_item(row.req, row.chk, row.exp_fired, row.exp_act);
            end
        end
        run_phase(REST_LEVEL_RST, INV_TAU_RST, STEPS_RST, INV_STEPS_RST, REFRACTORY_RST, 130);
        run_phase(act_t'($urandom()), RECIP_W'($urandom_range(0, 65536)), 8'd3,
                  RECIP_W'($urandom_range(0, 65536)), 16'd0, 100);
        run_phase(24'sd0, 17'd65536, 8'd255, 17'd256, 16'd2, 6);
        run_phase(-24'sd100000, 17'd0, 8'd1, 17'd0, 16'hFFFF, 30);
        run_phase(act_t'(int'($urandom_range(0, 2097152)) - 1048576),
                  RECIP_W'($urandom_range(0, 65536)), STEPS_W'($urandom_range(1, 20)),
                  RECIP_W'($urandom_range(0, 65536)), CNT_W'($urandom_range(0, 10)), 120);
        settle();
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
